FILE: hw/rtl/hpd_pkg.sv
// hpd_pkg: shared types, result codes and canonical huffman tables for the
// hpack huffman decoder. No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hpd_pkg;

    // code limits
    localparam int MaxCodeBits = 30;
    localparam int SymbolCount = 257;
    localparam int MaxPadBits  = 7;
    localparam int LenSlots    = 32;
    localparam logic [8:0] EosSymbol = 9'd256;

    // depth of the queue between front and back
    localparam int QueueDepthDef = 2;

    // result codes
    localparam logic [2:0] KIND_BYTE     = 3'd0;
    localparam logic [2:0] KIND_DONE     = 3'd1;
    localparam logic [2:0] KIND_EOS      = 3'd2;
    localparam logic [2:0] KIND_OVERLONG = 3'd3;
    localparam logic [2:0] KIND_PADDING  = 3'd4;
    localparam logic [2:0] KIND_LIMIT    = 3'd5;

    // input beat
    typedef struct packed {
        logic [7:0] coded_byte;
        logic       byte_present;
        logic       end_of_string;
    } t_in_item;

    // result beat
    typedef struct packed {
        logic [2:0]  result_kind;
        logic [7:0]  decoded_byte;
        logic [15:0] decoded_length;
        logic        last_result;
    } t_out_item;

    // classified work entry between front and back
    typedef struct packed {
        logic [7:0] coded_byte;
        logic       decode;
        logic       ending;
    } t_op;

    typedef logic [MaxCodeBits-1:0] t_code;
    typedef t_code      t_first_tab [LenSlots];
    typedef logic [8:0] t_cnt_tab   [LenSlots];
    typedef logic [8:0] t_sym_rom   [SymbolCount];
    typedef logic [4:0] t_len_tab   [SymbolCount];

    // code length of every symbol, rfc 7541 appendix b
    localparam t_len_tab CodeLen = '{
        13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
        28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
        6,10,10,12,13,6,8,11,10,10,8,11,8,6,6,6,
        5,5,5,6,6,6,6,6,6,6,7,8,15,6,12,10,
        13,6,7,7,7,7,7,7,7,7,7,7,7,7,7,7,
        7,7,7,7,7,7,7,7,8,7,8,13,19,13,14,6,
        15,5,6,5,6,5,6,6,6,5,7,7,6,6,6,5,
        6,7,6,5,5,6,7,7,7,7,7,15,11,14,13,28,
        20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
        24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
        22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
        21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
        26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
        19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
        20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
        26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26,
        30
    };

    // number of codes of each length
    function automatic t_cnt_tab calc_count();
        t_cnt_tab tab;
        for (int l = 0; l < LenSlots; l++) begin
            tab[l] = '0;
        end
        for (int s = 0; s < SymbolCount; s++) begin
            tab[CodeLen[s]] = tab[CodeLen[s]] + 9'd1;
        end
        tab[0] = '0;
        return tab;
    endfunction

    // first canonical code of each length
    function automatic t_first_tab calc_first();
        t_first_tab tab;
        t_cnt_tab   cnt;
        logic [31:0] code;
        cnt  = calc_count();
        code = '0;
        for (int l = 0; l < LenSlots; l++) begin
            tab[l] = '0;
        end
        for (int l = 1; l <= MaxCodeBits; l++) begin
            tab[l] = code[MaxCodeBits-1:0];
            code = (code + 32'(cnt[l])) << 1;
        end
        return tab;
    endfunction

    // rom position of the first symbol of each length
    function automatic t_cnt_tab calc_base();
        t_cnt_tab tab;
        t_cnt_tab cnt;
        logic [8:0] pos;
        cnt = calc_count();
        pos = '0;
        for (int l = 0; l < LenSlots; l++) begin
            tab[l] = pos;
            pos = pos + cnt[l];
        end
        return tab;
    endfunction

    // symbols ordered by length, then symbol value
    function automatic t_sym_rom calc_rom();
        t_sym_rom rom;
        int pos;
        pos = 0;
        for (int s = 0; s < SymbolCount; s++) begin
            rom[s] = '0;
        end
        for (int l = 1; l <= MaxCodeBits; l++) begin
            for (int s = 0; s < SymbolCount; s++) begin
                if (int'(CodeLen[s]) == l) begin
                    rom[pos] = 9'(s);
                    pos = pos + 1;
                end
            end
        end
        return rom;
    endfunction

    localparam t_first_tab LenFirst = calc_first();
    localparam t_cnt_tab   LenCount = calc_count();
    localparam t_cnt_tab   LenBase  = calc_base();
    localparam t_sym_rom   SymRom   = calc_rom();

endpackage

FILE: hw/rtl/hpd_front.sv
// hpd_front: accepts input beats, classifies them and queues the work for the back end.
// Depends on hpd_pkg (t_in_item, t_op).
`timescale 1ns / 1ps

module hpd_front #(
    parameter int QueueDepth = hpd_pkg::QueueDepthDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hpd_pkg::t_in_item i_item,
    input  logic              i_item_valid,
    output logic              o_item_ready,
    output hpd_pkg::t_op      o_op,
    output logic              o_op_valid,
    input  logic              i_op_pop
);
    import hpd_pkg::*;

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    t_op            r_mem [QueueDepth];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_cnt;

    logic w_accept;
    logic w_push;
    logic w_pop;
    t_op  w_op;

    // classify: an item with neither byte nor end marker does nothing, drop it
    always_comb begin
        w_op.coded_byte = i_item.coded_byte;
        w_op.decode     = i_item.byte_present;
        w_op.ending     = i_item.end_of_string;
    end

    assign o_item_ready = (r_cnt != CntW'(QueueDepth));
    assign w_accept     = i_item_valid && o_item_ready;
    assign w_push       = w_accept && (i_item.byte_present || i_item.end_of_string);
    assign o_op_valid   = (r_cnt != '0);
    assign w_pop        = i_op_pop && o_op_valid;
    assign o_op         = r_mem[r_rd];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_op;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PtrW'(QueueDepth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PtrW'(QueueDepth - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CntW'(w_push) - CntW'(w_pop);
        end
    end

endmodule

FILE: hw/rtl/hpd_back.sv
// hpd_back: bit-serial canonical huffman engine, end-of-string checks and result register.
// Depends on hpd_pkg (tables, result codes, t_op, t_out_item).
`timescale 1ns / 1ps

module hpd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hpd_pkg::t_op       i_op,
    input  logic               i_op_valid,
    output logic               o_op_pop,
    input  logic [15:0]        i_max_len,
    output hpd_pkg::t_out_item o_res,
    output logic               o_res_valid,
    input  logic               i_res_ready
);
    import hpd_pkg::*;

    typedef enum logic [1:0] {
        PH_BITS,
        PH_END,
        PH_FLUSH
    } t_phase;

    t_phase      r_phase;
    logic [2:0]  r_bit;
    t_code       r_code;
    logic [4:0]  r_cnt;
    logic [15:0] r_prod;
    logic        r_err;
    logic        r_hold_v;
    logic [2:0]  r_hold_kind;
    logic [7:0]  r_hold_byte;
    logic [15:0] r_hold_len;
    logic        r_out_v;
    t_out_item   r_out;

    logic        w_can_push;
    logic        w_bit;
    logic [4:0]  n_cnt;
    t_code       n_code;
    t_code       w_off;
    logic        w_hit;
    logic [8:0]  w_sym;
    logic        w_gen;
    logic [2:0]  w_kind;
    logic [7:0]  w_byte;
    logic [15:0] w_len;
    logic        w_adv;
    logic        w_out_load;
    logic        w_pad_ok;

    assign w_can_push = !r_out_v || i_res_ready;

    // one code bit: shift it in and look up the length's code range
    always_comb begin
        w_bit  = i_op.coded_byte[3'd7 - r_bit];
        n_cnt  = r_cnt + 5'd1;
        n_code = {r_code[MaxCodeBits-2:0], w_bit};
        w_off  = n_code - LenFirst[n_cnt];
        w_hit  = (LenCount[n_cnt] != '0) && (n_code >= LenFirst[n_cnt]) &&
                 (w_off < t_code'(LenCount[n_cnt]));
        w_sym  = SymRom[LenBase[n_cnt] + w_off[8:0]];
    end

    // padding: at most seven bits, all ones
    assign w_pad_ok = (r_cnt <= 5'(MaxPadBits)) &&
                      (r_code == ((t_code'(1) << r_cnt) - t_code'(1)));

    // result produced this cycle, if any
    always_comb begin
        w_gen  = 1'b0;
        w_kind = KIND_BYTE;
        w_byte = '0;
        w_len  = '0;
        case (r_phase)
            PH_BITS: begin
                if (i_op_valid && i_op.decode && !r_err) begin
                    if (n_cnt > 5'(MaxCodeBits)) begin
                        w_gen  = 1'b1;
                        w_kind = KIND_OVERLONG;
                    end else if (w_hit) begin
                        w_gen = 1'b1;
                        if (w_sym == EosSymbol) begin
                            w_kind = KIND_EOS;
                        end else if (r_prod >= i_max_len) begin
                            w_kind = KIND_LIMIT;
                        end else begin
                            w_kind = KIND_BYTE;
                            w_byte = w_sym[7:0];
                        end
                    end
                end
            end
            PH_END: begin
                if (i_op_valid && i_op.ending && !r_err) begin
                    w_gen = 1'b1;
                    if (w_pad_ok) begin
                        w_kind = KIND_DONE;
                        w_len  = r_prod;
                    end else begin
                        w_kind = KIND_PADDING;
                    end
                end
            end
            default: begin
                w_gen = 1'b0;
            end
        endcase
    end

    // a new result moves the held one out, which needs room downstream
    assign w_adv      = i_op_valid &&
                        ((r_phase == PH_FLUSH) ? (!r_hold_v || w_can_push)
                                               : (!w_gen || !r_hold_v || w_can_push));
    assign w_out_load = w_adv && r_hold_v && (w_gen || (r_phase == PH_FLUSH));
    assign o_op_pop   = w_adv && (r_phase == PH_FLUSH);

    // sequencer, decode state, held result and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_BITS;
            r_bit    <= '0;
            r_code   <= '0;
            r_cnt    <= '0;
            r_prod   <= '0;
            r_err    <= 1'b0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_v <= 1'b1;
            end else if (i_res_ready) begin
                r_out_v <= 1'b0;
            end
            if (w_adv) begin
                // push the held result on; it is the last one only at flush
                if (w_out_load) begin
                    r_out.result_kind         <= r_hold_kind;
                    r_out.decoded_byte        <= r_hold_byte;
                    r_out.decoded_length      <= r_hold_len;
                    r_out.last_result         <= (r_phase == PH_FLUSH);
                end
                if (w_gen) begin
                    r_hold_v    <= 1'b1;
                    r_hold_kind <= w_kind;
                    r_hold_byte <= w_byte;
                    r_hold_len  <= w_len;
                end else if (w_out_load) begin
                    r_hold_v    <= 1'b0;
                end
                case (r_phase)
                    PH_BITS: begin
                        if (!i_op.decode || r_err) begin
                            r_phase <= PH_END;
                        end else begin
                            if (w_gen && w_kind != KIND_BYTE) begin
                                r_err   <= 1'b1;
                                r_phase <= PH_END;
                            end else begin
                                if (w_gen) begin
                                    r_code <= '0;
                                    r_cnt  <= '0;
                                    r_prod <= r_prod + 16'd1;
                                end else begin
                                    r_code <= n_code;
                                    r_cnt  <= n_cnt;
                                end
                                if (r_bit == 3'd7) begin
                                    r_phase <= PH_END;
                                end
                            end
                            r_bit <= r_bit + 3'd1;
                        end
                    end
                    PH_END: begin
                        if (i_op.ending) begin
                            r_code <= '0;
                            r_cnt  <= '0;
                            r_prod <= '0;
                            r_err  <= 1'b0;
                        end
                        r_phase <= PH_FLUSH;
                    end
                    PH_FLUSH: begin
                        r_bit   <= '0;
                        r_phase <= PH_BITS;
                    end
                    default: begin
                        r_phase <= PH_BITS;
                    end
                endcase
            end
        end
    end

    assign o_res       = r_out;
    assign o_res_valid = r_out_v;

endmodule

FILE: hw/rtl/hpack_huffman_decoder.sv
// hpack_huffman_decoder: top level with apb limit register, front queue and decode engine.
// Depends on hpd_pkg, hpd_front and hpd_back.
//
//  channel   direction  handshake                     beat
//  item      in         i_item_valid / o_item_ready   hpd_pkg::t_in_item
//  result    out        o_res_valid / i_res_ready     hpd_pkg::t_out_item
//  config    in         psel penable pwrite pready    max_output_length at 0x0
//
// Each item with a byte walks its code bits in the decode engine, one code bit per cycle while
// the result path does not stall, through the canonical table lookup, then an end step and
// a flush step; an error ends the bit walk early, an end marker alone walks no code bits.
// The front queue takes new beats while the engine works; empty items cost nothing.
// A full result register stalls the engine only when it has a result to move.
// Reset is synchronous and active low, and restores the limit to 65535.
`timescale 1ns / 1ps

module hpack_huffman_decoder #(
    parameter int QueueDepth = hpd_pkg::QueueDepthDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hpd_pkg::t_in_item  i_item,
    input  logic               i_item_valid,
    output logic               o_item_ready,
    output hpd_pkg::t_out_item o_res,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import hpd_pkg::*;

    localparam logic REG_MAX_LEN = 1'b0;

    logic [15:0] r_max_len;
    t_op         w_op;
    logic        w_op_valid;
    logic        w_op_pop;

    // limit register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= 16'hFFFF;
        end else if (psel && penable && pwrite && paddr[2] == REG_MAX_LEN) begin
            r_max_len <= pwdata[15:0];
        end
    end
    assign prdata = (paddr[2] == REG_MAX_LEN) ? {16'd0, r_max_len} : 32'd0;

    hpd_front #(
        .QueueDepth(QueueDepth)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_item_valid(i_item_valid),
        .o_item_ready(o_item_ready),
        .o_op        (w_op),
        .o_op_valid  (w_op_valid),
        .i_op_pop    (w_op_pop)
    );

    hpd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_op),
        .i_op_valid (w_op_valid),
        .o_op_pop   (w_op_pop),
        .i_max_len  (r_max_len),
        .o_res      (o_res),
        .o_res_valid(o_res_valid),
        .i_res_ready(i_res_ready)
    );

    // checks
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.result_kind != KIND_BYTE |-> o_res.decoded_byte == 8'd0)
        else $error("decoded byte set on a non-byte result");

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.result_kind != KIND_DONE |-> o_res.decoded_length == 16'd0)
        else $error("length set on a result other than done");

    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.result_kind != KIND_BYTE |-> o_res.last_result)
        else $error("status result not marked last");

endmodule
